>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Simple implication checked on every rising clock edge.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Types, constants and byte classifiers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // Trailer after a zero size is CR LF CR LF: four steps.
    localparam logic [2:0] TRAIL_LEN = 3'd4;

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_DIGITS = 3'd1,
        PH_SKIP   = 3'd2,
        PH_DATA   = 3'd3,
        PH_TRAIL  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_ONGOING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAIL    = 2'd2
    } status_t;

    typedef struct packed {
        phase_t               phase;
        logic [SIZE_BITS-1:0] chunk_count;
        logic                 digit_seen;
        logic [2:0]           step_index;
        logic                 failed;
    } ctd_state_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        status_t    status;
    } ctd_result_t;

    localparam ctd_state_t STATE_RESET = '{
        phase:       PH_WS,
        chunk_count: '0,
        digit_seen:  1'b0,
        step_index:  3'd0,
        failed:      1'b0
    };

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})
            r = {1'b1, b[3:0]};
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b inside {[CHAR_TAB:CHAR_CR]});
    endfunction

endpackage

>>> src/ctd_step.sv
// ----------------------------------------------------------------------------
// ctd_step
// Next-state and result logic for one message byte.
// ----------------------------------------------------------------------------
module ctd_step
(
    input  ctd_pkg::ctd_state_t  cur,
    input  logic [7:0]           in_byte,
    input  logic                 is_last,
    output ctd_pkg::ctd_state_t  nxt,
    output ctd_pkg::ctd_result_t res
);

    logic [4:0]                    hex;
    logic                          is_hex;
    logic [3:0]                    digit;
    logic                          ovf;
    logic [ctd_pkg::SIZE_BITS-1:0] shifted;
    logic [ctd_pkg::SIZE_BITS-1:0] dec_count;
    logic [7:0]                    trail_char;
    ctd_pkg::ctd_state_t           upd;

    assign hex        = ctd_pkg::hex_decode(in_byte);
    assign is_hex     = hex[4];
    assign digit      = hex[3:0];
    assign dec_count  = cur.chunk_count - 1'b1;
    assign trail_char = cur.step_index[0] ? ctd_pkg::CHAR_LF : ctd_pkg::CHAR_CR;

    // Size digit append; in whitespace phase the size restarts from zero
    always_comb
    begin
        if (cur.phase == ctd_pkg::PH_WS)
        begin
            ovf     = 1'b0;
            shifted = {{(ctd_pkg::SIZE_BITS-4){1'b0}}, digit};
        end
        else
        begin
            ovf     = (cur.chunk_count[ctd_pkg::SIZE_BITS-1 -: 4] != 4'd0);
            shifted = {cur.chunk_count[ctd_pkg::SIZE_BITS-5:0], digit};
        end
    end

    always_comb
    begin
        upd                  = cur;
        res.payload_valid    = 1'b0;
        res.payload_byte     = 8'd0;
        res.status           = ctd_pkg::ST_ONGOING;

        if (!cur.failed)
        begin
            case (cur.phase)
                ctd_pkg::PH_WS,
                ctd_pkg::PH_DIGITS:
                begin
                    if (is_hex)
                    begin
                        upd.phase = ctd_pkg::PH_DIGITS;
                        if (ovf)
                        begin
                            upd.failed = 1'b1;
                        end
                        else
                        begin
                            upd.chunk_count = shifted;
                            upd.digit_seen  = 1'b1;
                        end
                    end
                    else if (cur.phase == ctd_pkg::PH_WS)
                    begin
                        if (!ctd_pkg::is_space(in_byte))
                            upd.failed = 1'b1;
                    end
                    else if (cur.chunk_count != '0)
                    begin
                        upd.phase      = ctd_pkg::PH_SKIP;
                        upd.step_index = 3'd1;
                    end
                    else if (in_byte == ctd_pkg::CHAR_CR)
                    begin
                        upd.phase      = ctd_pkg::PH_TRAIL;
                        upd.step_index = 3'd1;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
                ctd_pkg::PH_SKIP:
                begin
                    upd.phase      = ctd_pkg::PH_DATA;
                    upd.step_index = 3'd0;
                end
                ctd_pkg::PH_DATA:
                begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = in_byte;
                    upd.chunk_count   = dec_count;
                    if (dec_count == '0)
                    begin
                        upd.phase      = ctd_pkg::PH_WS;
                        upd.digit_seen = 1'b0;
                    end
                end
                ctd_pkg::PH_TRAIL:
                begin
                    if (cur.step_index < ctd_pkg::TRAIL_LEN && in_byte == trail_char)
                        upd.step_index = cur.step_index + 3'd1;
                    else
                        upd.failed = 1'b1;
                end
                default:
                begin
                    upd.failed = 1'b1;
                end
            endcase
        end

        if (is_last)
        begin
            if (!upd.failed && upd.phase == ctd_pkg::PH_TRAIL
                && upd.step_index == ctd_pkg::TRAIL_LEN)
                res.status = ctd_pkg::ST_DONE;
            else
                res.status = ctd_pkg::ST_FAIL;
            nxt = ctd_pkg::STATE_RESET;
        end
        else
        begin
            nxt = upd;
        end
    end

endmodule

>>> src/chunked_transfer_decoder_top.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_top
// Chunked body decoder: one result item per input byte, payload passed out.
// ----------------------------------------------------------------------------
// Path: input accept to result valid runs through input reg, then result reg.
// Throughput: 1 item per cycle while out_stall is low; the decode state loop
//   closes through ctd_step, between the input and the result register.
// Reset: rst_n async low; both stages empty, decoder state back to the
//   whitespace-before-size phase with size, step and failure cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_transfer_decoder_top
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [1:0] status
);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Decoder state and result stage
    ctd_pkg::ctd_state_t  state_reg;
    ctd_pkg::ctd_state_t  state_next;
    ctd_pkg::ctd_result_t res_next;
    ctd_pkg::ctd_result_t res_reg;
    logic                 out_valid_reg;

    logic out_load;   // result register can take a new item
    logic advance;    // input stage item moves into result stage
    logic in_take;

    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_load;
    // Input register is free when empty or draining this cycle
    assign in_stall = in_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= is_last;
        end
    end

    ctd_step u_step
    (
        .cur     (state_reg),
        .in_byte (in_byte_reg),
        .is_last (in_last_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // State only moves when the item is committed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ctd_pkg::STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = res_reg.payload_valid;
    assign payload_byte  = res_reg.payload_byte;
    assign status        = res_reg.status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_IMPL(a_stall_needs_item, in_stall, in_valid_reg, "stall with empty input stage")
    `ASSERT_NEXT(a_last_resets, advance && in_last_reg, state_reg == ctd_pkg::STATE_RESET, "state not reset after last byte")
    `ASSERT_IMPL(a_data_not_done, out_valid_reg && res_reg.payload_valid, res_reg.status != ctd_pkg::ST_DONE, "data byte reported as finished")
    `ASSERT_IMPL(a_trail_bound, state_reg.phase == ctd_pkg::PH_TRAIL, state_reg.step_index <= ctd_pkg::TRAIL_LEN, "trailer step out of range")

endmodule
